[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Every check samples on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

[rtl/ccdlm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ccdlm_pkg;

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int CFG_W    = 13;
   localparam int COUNT_W  = 13;
   localparam int PORT_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Default depth of the sample store.
   localparam int MAX_SAMPLES_DEF = 4096;

   // Saturation level of a window count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register reset values.
   localparam logic [CFG_W-1:0] LINE_LENGTH_RST  = CFG_W'(2100);
   localparam logic [CFG_W-1:0] LEFT_WIDTH_RST   = CFG_W'(600);
   localparam logic [CFG_W-1:0] MIDDLE_WIDTH_RST = CFG_W'(900);
   localparam logic [CFG_W-1:0] RIGHT_WIDTH_RST  = CFG_W'(600);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_WIDTH   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_WIDTH = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WIDTH  = CSR_IDX_W'(3);

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_DIVIDE,
      ST_SCAN,
      ST_DONE
   } ccd_state_type;

   // Gathers the sample bits scattered over the two port words.
   function automatic logic [SAMPLE_W-1:0] permute_sample(
      input logic [PORT_W-1:0] b,
      input logic [PORT_W-1:0] c
   );
      permute_sample = {c[4], c[5], b[0], b[1], b[2], b[10], b[11],
                        b[7], b[8], b[9], c[0], c[1]};
   endfunction

endpackage

`default_nettype wire

[rtl/ccd_line_mean_threshold_counter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Collects one sample per cycle while in the collect phase; req_ready is high only in that phase.
// After the item that closes a line of n samples the unit runs a radix-2 restoring divider
// for the mean, then scans the store at one read per cycle and counts samples above the mean.
// Synchronous active-high reset clears the sequencer, positions, sum, counts, configuration
// registers and result valid flag; the sample store is not cleared and needs no clearing pass.

module ccd_line_mean_threshold_counter_unit
   import ccdlm_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   // Input item channel.
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [PORT_W-1:0]     req_port_b_word,
   input  wire  [PORT_W-1:0]     req_port_c_word,
   // Result item channel.
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [COUNT_W-1:0]    rsp_left_count,
   output logic [COUNT_W-1:0]    rsp_middle_count,
   output logic [COUNT_W-1:0]    rsp_right_count,
   output logic [SAMPLE_W-1:0]   rsp_line_mean,
   // Configuration write port.
   input  wire                   csr_write_enable,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CFG_W-1:0]      csr_write_data
);

   // Position width holds the depth itself; address width indexes the store.
   localparam int PW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int SW = SAMPLE_W + PW;
   localparam int EW = CFG_W + 2;
   localparam int XW = (PW > EW) ? PW : EW;
   localparam int STEP_W = $clog2(SAMPLE_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_W - 1);

   // Configuration registers.
   logic [CFG_W-1:0] line_length_ff, left_width_ff, middle_width_ff, right_width_ff;

   // Sequencer.
   ccd_state_type state_ff, state_in;

   // Collect phase state.
   logic [PW-1:0] wp_ff;
   logic [SW-1:0] sum_ff;

   // Divider state: partial remainder, and low sum bits turning into the quotient.
   logic [PW-1:0]       n_ff;
   logic [PW-1:0]       rem_ff;
   logic [SAMPLE_W-1:0] quo_ff;
   logic [STEP_W-1:0]   step_ff;

   // Window bounds captured at line close.
   logic [EW-1:0] e1_ff, e2_ff, e3_ff;

   // Scan state.
   logic [PW-1:0]       scan_ff;
   logic                pend_ff;
   logic [AW-1:0]       pend_idx_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [COUNT_W-1:0]  left_cnt_ff, middle_cnt_ff, right_cnt_ff;

   // Result holding register.
   logic                rsp_valid_ff;
   logic [COUNT_W-1:0]  rsp_left_ff, rsp_middle_ff, rsp_right_ff;
   logic [SAMPLE_W-1:0] rsp_mean_ff;

   // Sample store.
   logic [SAMPLE_W-1:0] store [MAX_SAMPLES];

   // Control decoded from the state.
   logic req_ready_int, rd_en, div_step, load_rsp;

   // Datapath.
   logic [SAMPLE_W-1:0] sample;
   logic [SW-1:0]       sum_total;
   logic [PW-1:0]       wp_inc;
   logic [XW-1:0]       len_x, eff_len;
   logic                accept, close_line;
   logic [PW:0]         trial;
   logic                trial_ge;
   logic [XW-1:0]       pend_idx_x;
   logic                above_mean;
   logic [EW-1:0]       e1_in, e2_in, e3_in;

   // Sample assembly, running sum and line-close test.
   always_comb begin
      sample    = permute_sample(req_port_b_word, req_port_c_word);
      sum_total = sum_ff + SW'(sample);
      wp_inc    = wp_ff + PW'(1);
      len_x     = XW'(line_length_ff);
      if (len_x == '0) begin
         eff_len = XW'(1);
      end else if (len_x > XW'(MAX_SAMPLES)) begin
         eff_len = XW'(MAX_SAMPLES);
      end else begin
         eff_len = len_x;
      end
      accept     = req_valid && req_ready_int;
      close_line = XW'(wp_inc) >= eff_len;
      e1_in      = EW'(left_width_ff);
      e2_in      = e1_in + EW'(middle_width_ff);
      e3_in      = e2_in + EW'(right_width_ff);
   end

   // One restoring division step per cycle.
   always_comb begin
      trial    = {rem_ff, quo_ff[SAMPLE_W-1]};
      trial_ge = trial >= {1'b0, n_ff};
   end

   // Compare of the sample read in the previous cycle.
   always_comb begin
      pend_idx_x = XW'(pend_idx_ff);
      above_mean = rd_data_ff > quo_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && close_line) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!rd_en && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_ready_int = 1'b0;
      rd_en         = 1'b0;
      div_step      = 1'b0;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_COLLECT: req_ready_int = 1'b1;
         ST_DIVIDE:  div_step = 1'b1;
         ST_SCAN:    rd_en = scan_ff < n_ff;
         ST_DONE:    load_rsp = !rsp_valid_ff || rsp_ready;
         default:    req_ready_int = 1'b0;
      endcase
   end

   // Store write while collecting, registered read while scanning.
   always_ff @(posedge clock) begin
      if (accept) begin
         store[wp_ff[AW-1:0]] <= sample;
      end
      if (rd_en) begin
         rd_data_ff <= store[scan_ff[AW-1:0]];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= LINE_LENGTH_RST;
         left_width_ff   <= LEFT_WIDTH_RST;
         middle_width_ff <= MIDDLE_WIDTH_RST;
         right_width_ff  <= RIGHT_WIDTH_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINE_LENGTH:  line_length_ff  <= csr_write_data;
            CSR_LEFT_WIDTH:   left_width_ff   <= csr_write_data;
            CSR_MIDDLE_WIDTH: middle_width_ff <= csr_write_data;
            CSR_RIGHT_WIDTH:  right_width_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer, collect phase and scan control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         wp_ff         <= '0;
         sum_ff        <= '0;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         left_cnt_ff   <= '0;
         middle_cnt_ff <= '0;
         right_cnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_en;
         if (accept) begin
            if (close_line) begin
               wp_ff         <= '0;
               sum_ff        <= '0;
               scan_ff       <= '0;
               left_cnt_ff   <= '0;
               middle_cnt_ff <= '0;
               right_cnt_ff  <= '0;
            end else begin
               wp_ff  <= wp_inc;
               sum_ff <= sum_total;
            end
         end
         if (rd_en) begin
            scan_ff <= scan_ff + PW'(1);
         end
         // Classify the position against the three windows and count.
         if (pend_ff && above_mean) begin
            priority if (pend_idx_x < XW'(e1_ff)) begin
               if (left_cnt_ff != COUNT_MAX) left_cnt_ff <= left_cnt_ff + COUNT_W'(1);
            end else if (pend_idx_x < XW'(e2_ff)) begin
               if (middle_cnt_ff != COUNT_MAX) middle_cnt_ff <= middle_cnt_ff + COUNT_W'(1);
            end else if (pend_idx_x < XW'(e3_ff)) begin
               if (right_cnt_ff != COUNT_MAX) right_cnt_ff <= right_cnt_ff + COUNT_W'(1);
            end else begin
               // Positions past the third window are not counted.
            end
         end
      end
   end

   // Divider and captured line parameters.
   always_ff @(posedge clock) begin
      if (accept && close_line) begin
         n_ff    <= wp_inc;
         rem_ff  <= sum_total[SW-1:SAMPLE_W];
         quo_ff  <= sum_total[SAMPLE_W-1:0];
         step_ff <= '0;
         e1_ff   <= e1_in;
         e2_ff   <= e2_in;
         e3_ff   <= e3_in;
      end else if (div_step) begin
         rem_ff  <= trial_ge ? PW'(trial - {1'b0, n_ff}) : PW'(trial);
         quo_ff  <= {quo_ff[SAMPLE_W-2:0], trial_ge};
         step_ff <= step_ff + STEP_W'(1);
      end
      if (rd_en) begin
         pend_idx_ff <= scan_ff[AW-1:0];
      end
   end

   // Result holding register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_left_ff   <= left_cnt_ff;
         rsp_middle_ff <= middle_cnt_ff;
         rsp_right_ff  <= right_cnt_ff;
         rsp_mean_ff   <= quo_ff;
      end
   end

   assign req_ready        = req_ready_int;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_count   = rsp_left_ff;
   assign rsp_middle_count = rsp_middle_ff;
   assign rsp_right_count  = rsp_right_ff;
   assign rsp_line_mean    = rsp_mean_ff;

`include "assert_macros.svh"

   // The write position always addresses a real store entry.
   `ASSERT_ALWAYS(a_wp_in_range, wp_ff < PW'(MAX_SAMPLES), "write position past the store")
   // The partial remainder stays below the divisor throughout the division.
   `ASSERT_ALWAYS(a_rem_below_n, (state_ff != ST_DIVIDE) || (rem_ff < n_ff), "remainder overflow")
   // The scan never reads past the collected line.
   `ASSERT_ALWAYS(a_scan_bound, (state_ff != ST_SCAN) || (scan_ff <= n_ff), "scan beyond line")
   // A closing item starts the division in the next cycle.
   `ASSERT_NEXT(a_close_divides, accept && close_line, state_ff == ST_DIVIDE, "no divide")

endmodule

`default_nettype wire
